// ----- sv/thfd_pkg.sv -----
// thfd_pkg: shared types, constants and the crc-8 step for the temperature and
// humidity frame decoder. Used by the decoder top level and its checker.
// No dependencies.
`default_nettype none

package thfd_pkg;

   // crc-8, polynomial 0x31, preset 0xff, msb first
   localparam logic [7:0] CHECK_POLY = 8'h31;
   localparam logic [7:0] CHECK_INIT = 8'hFF;

   // byte positions inside one six-byte reply
   localparam logic [2:0] POS_TEMP_MSB = 3'd0;
   localparam logic [2:0] POS_TEMP_LSB = 3'd1;
   localparam logic [2:0] POS_TEMP_CRC = 3'd2;
   localparam logic [2:0] POS_HUM_MSB  = 3'd3;
   localparam logic [2:0] POS_HUM_LSB  = 3'd4;
   localparam logic [2:0] POS_HUM_CRC  = 3'd5;

   // temperature: floor(raw * 17500 / 65535) - 4500
   localparam int unsigned TEMP_PROD_W = 31;
   localparam logic [30:0] TEMP_SCALE      = 31'd17500;
   localparam logic [16:0] TEMP_FULL_SCALE = 17'd65535;
   localparam logic [15:0] TEMP_OFFSET     = 16'd4500;
   localparam int          TEMP_MIN        = -4500;
   localparam int          TEMP_MAX        = 13000;

   // humidity: (625 * raw) >> 12
   localparam int unsigned HUM_PROD_W  = 26;
   localparam int unsigned HUM_SHIFT   = 12;
   localparam logic [25:0] HUM_SCALE   = 26'd625;
   localparam logic [13:0] HUM_MAX     = 14'd9999;

   // one received byte of the sensor reply
   typedef struct packed {
      logic [7:0] data_byte;
      logic       frame_start;
   } req_type;

   // decoded reading
   typedef struct packed {
      logic signed [14:0] temp_centi;
      logic [13:0]        humidity_centi;
      logic               temp_check_ok;
      logic               humidity_check_ok;
   } rsp_type;

   // one byte through the crc, eight shift steps unrolled
   function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
      logic [7:0] c;
      c = crc ^ b;
      for (int k = 0; k < 8; k++) begin
         if (c[7]) begin
            c = {c[6:0], 1'b0} ^ CHECK_POLY;
         end else begin
            c = {c[6:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

`default_nettype wire

// ----- sv/temp_humidity_frame_decoder.sv -----
// temp_humidity_frame_decoder: byte-wise decoder of a six-byte temperature and
// humidity sensor reply with crc checks and fixed-point scaling.
// Depends on thfd_pkg.
//
// Usage:
//   req channel carries one reply byte per transaction plus a frame_start flag
//   that forces the byte to position zero (temp msb). Bytes without the flag
//   take the next position and wrap after the sixth, so replies may follow
//   each other with no flag at all.
//   rsp channel carries one decoded reading per complete reply, issued from an
//   output register in the cycle after the sixth byte is taken.
//   Throughput is one byte per cycle while req_stall is low. The temperature
//   scaling multiply runs when the temperature crc byte arrives, the humidity
//   multiply on the last byte. While a reading waits under rsp_stall the
//   block keeps taking the first five bytes of the next reply; it stalls only
//   when the registered position is the last byte and the output register is
//   still full.
//   Synchronous active-high reset empties the output register and returns the
//   position to zero and the crc to its preset.
//   A crc mismatch still yields a reading, with the matching flag cleared.
`default_nettype none

module temp_humidity_frame_decoder (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire thfd_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output thfd_pkg::rsp_type      rsp_data
);

   logic [2:0]                       pos_ff, pos_in, pos_cur;
   logic [7:0]                       crc_ff, crc_in, crc_cur, crc_next;
   logic [15:0]                      temp_raw_ff, temp_raw_in;
   logic [15:0]                      hum_raw_ff, hum_raw_in;
   logic                             temp_match_ff, temp_match_in;
   logic [thfd_pkg::TEMP_PROD_W-1:0] temp_prod_ff, temp_prod_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   thfd_pkg::rsp_type                rsp_data_ff, rsp_data_in;

   logic                             req_accept;
   logic                             restart;
   logic [14:0]                      prod_hi;
   logic [15:0]                      prod_lo;
   logic [16:0]                      fold_sum;
   logic [15:0]                      quot;
   logic [15:0]                      temp_val;
   logic [thfd_pkg::HUM_PROD_W-1:0]  hum_prod;

   // input handshake: hold off only the last byte while a reading is stuck
   assign req_stall  = rsp_valid_ff & rsp_stall & (pos_ff == thfd_pkg::POS_HUM_CRC);
   assign req_accept = req_valid & ~req_stall;

   // effective position and crc after frame start or an unused code
   assign restart  = req_data.frame_start | (pos_ff > thfd_pkg::POS_HUM_CRC);
   assign pos_cur  = restart ? thfd_pkg::POS_TEMP_MSB : pos_ff;
   assign crc_cur  = restart ? thfd_pkg::CHECK_INIT : crc_ff;
   assign crc_next = thfd_pkg::crc8_update(crc_cur, req_data.data_byte);

   // divide by 65535: high half plus one fold correction of high + low
   assign prod_hi  = temp_prod_ff[30:16];
   assign prod_lo  = temp_prod_ff[15:0];
   assign fold_sum = {2'b00, prod_hi} + {1'b0, prod_lo};
   assign quot     = {1'b0, prod_hi} + 16'(fold_sum >= thfd_pkg::TEMP_FULL_SCALE);
   assign temp_val = quot - thfd_pkg::TEMP_OFFSET;

   // humidity scaling
   assign hum_prod = thfd_pkg::HUM_PROD_W'(hum_raw_ff) * thfd_pkg::HUM_SCALE;

   // byte sequencing and result capture
   always_comb begin
      pos_in        = pos_ff;
      crc_in        = crc_ff;
      temp_raw_in   = temp_raw_ff;
      hum_raw_in    = hum_raw_ff;
      temp_match_in = temp_match_ff;
      temp_prod_in  = temp_prod_ff;
      rsp_valid_in  = rsp_valid_ff & rsp_stall;
      rsp_data_in   = rsp_data_ff;
      if (req_accept) begin
         unique case (pos_cur)
            thfd_pkg::POS_TEMP_MSB: begin
               temp_raw_in = {req_data.data_byte, temp_raw_ff[7:0]};
               crc_in      = crc_next;
               pos_in      = thfd_pkg::POS_TEMP_LSB;
            end
            thfd_pkg::POS_TEMP_LSB: begin
               temp_raw_in = {temp_raw_ff[15:8], req_data.data_byte};
               crc_in      = crc_next;
               pos_in      = thfd_pkg::POS_TEMP_CRC;
            end
            thfd_pkg::POS_TEMP_CRC: begin
               temp_match_in = (req_data.data_byte == crc_cur);
               temp_prod_in  = thfd_pkg::TEMP_PROD_W'(temp_raw_ff) * thfd_pkg::TEMP_SCALE;
               crc_in        = thfd_pkg::CHECK_INIT;
               pos_in        = thfd_pkg::POS_HUM_MSB;
            end
            thfd_pkg::POS_HUM_MSB: begin
               hum_raw_in = {req_data.data_byte, hum_raw_ff[7:0]};
               crc_in     = crc_next;
               pos_in     = thfd_pkg::POS_HUM_LSB;
            end
            thfd_pkg::POS_HUM_LSB: begin
               hum_raw_in = {hum_raw_ff[15:8], req_data.data_byte};
               crc_in     = crc_next;
               pos_in     = thfd_pkg::POS_HUM_CRC;
            end
            default: begin
               rsp_data_in.temp_centi        = signed'(temp_val[14:0]);
               rsp_data_in.humidity_centi    =
                  hum_prod[thfd_pkg::HUM_PROD_W-1:thfd_pkg::HUM_SHIFT];
               rsp_data_in.temp_check_ok     = temp_match_ff;
               rsp_data_in.humidity_check_ok = (req_data.data_byte == crc_cur);
               rsp_valid_in                  = 1'b1;
               crc_in                        = thfd_pkg::CHECK_INIT;
               pos_in                        = thfd_pkg::POS_TEMP_MSB;
            end
         endcase
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff        <= thfd_pkg::POS_TEMP_MSB;
         crc_ff        <= thfd_pkg::CHECK_INIT;
         temp_match_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         pos_ff        <= pos_in;
         crc_ff        <= crc_in;
         temp_match_ff <= temp_match_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      temp_raw_ff  <= temp_raw_in;
      hum_raw_ff   <= hum_raw_in;
      temp_prod_ff <= temp_prod_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

// ----- sv/thfd_checker.sv -----
// thfd_checker: port-level assertions for the temperature and humidity frame
// decoder, bound to the top level. Depends on thfd_pkg.
`default_nettype none

module thfd_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_valid,
   input wire logic              req_stall,
   input wire thfd_pkg::req_type req_data,
   input wire logic              rsp_valid,
   input wire logic              rsp_stall,
   input wire thfd_pkg::rsp_type rsp_data
);

   // a stalled reading holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("reading changed or dropped under stall");

   // reset empties the output register
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("reading present after reset");

   // a new reading follows an accepted transaction
   a_rsp_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && !req_stall))
      else $error("reading without an accepted byte");

   // a frame start byte never completes a reply
   a_start_no_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_data.frame_start && !rsp_valid |=> !rsp_valid)
      else $error("reading after a frame start byte");

   // decoded values stay in range
   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (int'(rsp_data.temp_centi) >= thfd_pkg::TEMP_MIN)
                 && (int'(rsp_data.temp_centi) <= thfd_pkg::TEMP_MAX)
                 && (rsp_data.humidity_centi <= thfd_pkg::HUM_MAX))
      else $error("decoded value out of range");

endmodule

bind temp_humidity_frame_decoder thfd_checker u_thfd_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

`default_nettype wire
